[src/memory_test_pattern_checker_top_assert.svh]
// Assertion macros for the memory test pattern checker
`ifndef MEMORY_TEST_PATTERN_CHECKER_TOP_ASSERT_SVH
`define MEMORY_TEST_PATTERN_CHECKER_TOP_ASSERT_SVH

// antecedent and consequent in the same cycle
`define MTPC_ASSERT_SAME(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("mtpc assertion failed");

// consequent in the cycle after the antecedent
`define MTPC_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("mtpc assertion failed");

`endif

[src/mtpc_pkg.sv]
// Types, constants and helpers shared by the pattern checker modules
package mtpc_pkg;

  localparam int unsigned ADDR_W = 31;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned PASS_W = 3;
  localparam int unsigned OUT_QUEUE_DEPTH = 2;
  localparam int unsigned HASH_SHIFT = 29;

  localparam logic [31:0] HASH_MUL_ADDR_LO = 32'h7f4a7c15;
  localparam logic [31:0] HASH_MUL_ADDR_HI = 32'h9e3779b9;
  localparam logic [63:0] HASH_MUL_PASS = 64'hd1b54a32d192ed03;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_VERIFY = 1'b1
  } op_t;

  // word handed from front to back
  typedef struct packed {
    op_t               op;
    logic              inj;
    logic [ADDR_W-1:0] addr;
    logic [63:0]       prod_lo;
    logic [31:0]       prod_hi;
    logic [63:0]       pass_term;
    logic [63:0]       read_data;
  } work_t;

  typedef struct packed {
    logic [63:0]       pattern_data;
    logic              mismatch_now;
    logic              fail_seen;
    logic [ADDR_W-1:0] first_fail_address;
    logic [63:0]       first_fail_expected;
    logic [63:0]       first_fail_actual;
  } result_t;

  typedef struct packed {
    logic fire;
    logic is_verify;
    logic miss;
    logic fail_flag;
  } back_status_t;

  // (pass + 1) * K2, eight entries
  function automatic logic [63:0] pass_term(input logic [PASS_W-1:0] pass);
    logic [63:0] p1;
    p1 = 64'(pass) + 64'd1;
    return p1 * HASH_MUL_PASS;
  endfunction

endpackage

[src/mtpc_fifo.sv]
// Small register-based FIFO used between pipeline parts
module mtpc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

[src/mtpc_front.sv]
// Front end: accepts words, masks address, classifies, forms partial products
module mtpc_front #(
  parameter int unsigned ADDR_BITS = 31
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        op,
  input  logic [mtpc_pkg::ADDR_W-1:0] word_address,
  input  logic [mtpc_pkg::PASS_W-1:0] pass_number,
  input  logic [63:0]                 read_data,
  input  logic                        inject_error,
  output logic                        mid_push,
  output mtpc_pkg::work_t             mid_wdata,
  input  logic                        mid_full
);

  import mtpc_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  logic              s1_valid;
  work_t             s1;
  work_t             s1_next;
  logic              advance;
  logic [ADDR_W-1:0] addr_m;
  logic [31:0]       addr_ext;

  assign advance  = !s1_valid || !mid_full;
  assign full     = !advance;
  assign mid_push = s1_valid;
  assign mid_wdata = s1;

  assign addr_m   = word_address & ADDR_MASK;
  assign addr_ext = 32'(addr_m);

  always_comb begin
    s1_next.op        = op_t'(op);
    s1_next.inj       = inject_error && (op_t'(op) == OP_WRITE) && (addr_m == '0)
                        && (pass_number == '0);
    s1_next.addr      = addr_m;
    s1_next.prod_lo   = 64'(addr_ext) * 64'(HASH_MUL_ADDR_LO);
    s1_next.prod_hi   = addr_ext * HASH_MUL_ADDR_HI;
    s1_next.pass_term = pass_term(pass_number);
    s1_next.read_data = read_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && push) begin
      s1 <= s1_next;
    end
  end

endmodule

[src/mtpc_back.sv]
// Back end: finishes the hash, compares, keeps the first-failure capture
module mtpc_back (
  input  logic                   clk,
  input  logic                   rst,
  input  mtpc_pkg::work_t        mid_rdata,
  input  logic                   mid_empty,
  output logic                   mid_pop,
  output logic                   out_push,
  output mtpc_pkg::result_t      out_wdata,
  input  logic                   out_full,
  output mtpc_pkg::back_status_t status
);

  import mtpc_pkg::*;

  logic              fail_flag;
  logic [ADDR_W-1:0] fail_address;
  logic [63:0]       fail_expected_word;
  logic [63:0]       fail_actual_word;

  logic              fire;
  logic [31:0]       sum_hi;
  logic [63:0]       v;
  logic [63:0]       expected;
  logic              miss;
  logic              capture;

  assign fire     = !mid_empty && !out_full;
  assign mid_pop  = fire;
  assign out_push = fire;

  assign sum_hi   = mid_rdata.prod_hi + mid_rdata.prod_lo[63:32];
  assign v        = {sum_hi, mid_rdata.prod_lo[31:0]} ^ mid_rdata.pass_term;
  assign expected = v ^ (v >> HASH_SHIFT);
  assign miss     = (mid_rdata.op == OP_VERIFY) && (mid_rdata.read_data != expected);
  assign capture  = fire && miss && !fail_flag;

  always_comb begin
    out_wdata.pattern_data        = expected ^ 64'(mid_rdata.inj);
    out_wdata.mismatch_now        = miss;
    out_wdata.fail_seen           = fail_flag || miss;
    out_wdata.first_fail_address  = capture ? mid_rdata.addr : fail_address;
    out_wdata.first_fail_expected = capture ? expected : fail_expected_word;
    out_wdata.first_fail_actual   = capture ? mid_rdata.read_data : fail_actual_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fail_flag          <= 1'b0;
      fail_address       <= '0;
      fail_expected_word <= '0;
      fail_actual_word   <= '0;
    end else if (capture) begin
      fail_flag          <= 1'b1;
      fail_address       <= mid_rdata.addr;
      fail_expected_word <= expected;
      fail_actual_word   <= mid_rdata.read_data;
    end
  end

  always_comb begin
    status.fire      = fire;
    status.is_verify = (mid_rdata.op == OP_VERIFY);
    status.miss      = miss;
    status.fail_flag = fail_flag;
  end

endmodule

[src/memory_test_pattern_checker_top.sv]
// Top level of the memory test pattern checker
//
//   channel   handshake                 payload
//   input     push / full               op, word_address, pass_number, read_data
//   result    empty / pop               pattern_data, mismatch_now, fail_seen,
//                                       first_fail_address/expected/actual
//   config    cfg_valid / cfg_ready     cfg_data (inject_error)
//
// One word per cycle sustained while the result side keeps popping; a pushed word passes through
// the partial-product register, the work queue and the result queue before empty goes low.
// The 64-bit address product is two 32x32 multiplies in the front register stage.
// rst is synchronous, active high; clears queues and the failure capture.
// Front and back stall independently through the work queue; cfg_ready is always high.
module memory_test_pattern_checker_top #(
  parameter int unsigned ADDR_BITS   = 31,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        op,
  input  logic [mtpc_pkg::ADDR_W-1:0] word_address,
  input  logic [mtpc_pkg::PASS_W-1:0] pass_number,
  input  logic [63:0]                 read_data,
  output logic                        empty,
  input  logic                        pop,
  output logic [63:0]                 pattern_data,
  output logic                        mismatch_now,
  output logic                        fail_seen,
  output logic [mtpc_pkg::ADDR_W-1:0] first_fail_address,
  output logic [63:0]                 first_fail_expected,
  output logic [63:0]                 first_fail_actual,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_data
);

  import mtpc_pkg::*;

  `include "memory_test_pattern_checker_top_assert.svh"

  logic         inject_error;
  logic         mid_push;
  work_t        mid_wdata;
  logic         mid_full;
  logic         mid_pop;
  work_t        mid_rdata;
  logic         mid_empty;
  logic         out_push;
  result_t      out_wdata;
  logic         out_full;
  result_t      out_rdata;
  back_status_t back_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inject_error <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      inject_error <= cfg_data;
    end
  end

  mtpc_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .op           (op),
    .word_address (word_address),
    .pass_number  (pass_number),
    .read_data    (read_data),
    .inject_error (inject_error),
    .mid_push     (mid_push),
    .mid_wdata    (mid_wdata),
    .mid_full     (mid_full)
  );

  mtpc_fifo #(
    .WIDTH ($bits(work_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_work_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  mtpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_rdata (mid_rdata),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .out_push  (out_push),
    .out_wdata (out_wdata),
    .out_full  (out_full),
    .status    (back_status)
  );

  mtpc_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_QUEUE_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wdata),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign pattern_data        = out_rdata.pattern_data;
  assign mismatch_now        = out_rdata.mismatch_now;
  assign fail_seen           = out_rdata.fail_seen;
  assign first_fail_address  = out_rdata.first_fail_address;
  assign first_fail_expected = out_rdata.first_fail_expected;
  assign first_fail_actual   = out_rdata.first_fail_actual;

  `MTPC_ASSERT_NEXT(a_fail_sticky, clk, rst, back_status.fail_flag, back_status.fail_flag)
  `MTPC_ASSERT_NEXT(a_miss_sets_flag, clk, rst, back_status.fire && back_status.miss, back_status.fail_flag)
  `MTPC_ASSERT_SAME(a_write_no_miss, clk, rst, !back_status.is_verify, !back_status.miss)

endmodule

[dv/memory_test_pattern_checker_checker.sv]
// Pattern hash for stimulus and prediction, and the result checker of the pattern engine
package mtpc_hash_pkg;
  import mtpc_pkg::*;

  localparam logic [63:0] ADDR_MUL = {HASH_MUL_ADDR_HI, HASH_MUL_ADDR_LO};

  function automatic logic [63:0] hash_pattern(input logic [ADDR_W-1:0] addr,
                                               input logic [PASS_W-1:0] pass);
    logic [63:0] mix;
    mix = (64'(addr) * ADDR_MUL) ^ ((64'(pass) + 64'd1) * HASH_MUL_PASS);
    return mix ^ (mix >> HASH_SHIFT);
  endfunction
endpackage

module pattern_result_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic                        full,
  input  logic                        op,
  input  logic [mtpc_pkg::ADDR_W-1:0] word_address,
  input  logic [mtpc_pkg::PASS_W-1:0] pass_number,
  input  logic [63:0]                 read_data,
  input  logic                        empty,
  input  logic                        pop,
  input  logic [63:0]                 pattern_data,
  input  logic                        mismatch_now,
  input  logic                        fail_seen,
  input  logic [mtpc_pkg::ADDR_W-1:0] first_fail_address,
  input  logic [63:0]                 first_fail_expected,
  input  logic [63:0]                 first_fail_actual,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic                        cfg_data,
  output int                          fail_count,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mtpc_pkg::*;
  import mtpc_hash_pkg::*;

  result_t           expected_results[$];
  result_t           want;
  logic              inject_on;
  logic              capt_flag;
  logic [ADDR_W-1:0] capt_addr;
  logic [63:0]       capt_expected;
  logic [63:0]       capt_actual;
  logic [63:0]       golden;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_results.delete();
      inject_on = 1'b0;
      capt_flag = 1'b0;
      capt_addr = '0;
      capt_expected = '0;
      capt_actual = '0;
    end else begin
      if (push && !full) begin
        golden = hash_pattern(word_address, pass_number);
        want.pattern_data = golden;
        want.mismatch_now = 1'b0;
        if (op_t'(op) == OP_WRITE) begin
          if (inject_on && word_address == '0 && pass_number == '0)
            want.pattern_data = golden ^ 64'd1;
        end else if (read_data != golden) begin
          want.mismatch_now = 1'b1;
          if (!capt_flag) begin
            capt_flag = 1'b1;
            capt_addr = word_address;
            capt_expected = golden;
            capt_actual = read_data;
          end
        end
        want.fail_seen = capt_flag;
        want.first_fail_address = capt_addr;
        want.first_fail_expected = capt_expected;
        want.first_fail_actual = capt_actual;
        expected_results.push_back(want);
      end
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result word with no expectation pending");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("pattern_data", want.pattern_data, pattern_data);
          check_field("mismatch_now", want.mismatch_now, mismatch_now);
          check_field("fail_seen", want.fail_seen, fail_seen);
          check_field("first_fail_address", want.first_fail_address, first_fail_address);
          check_field("first_fail_expected", want.first_fail_expected, first_fail_expected);
          check_field("first_fail_actual", want.first_fail_actual, first_fail_actual);
        end
      end
      if (cfg_valid && cfg_ready)
        inject_on = cfg_data;
    end
    pending = expected_results.size();
  end
endmodule

[dv/tb_memory_test_pattern_checker_top.sv]
// Testbench top for the memory test pattern checker: stimulus, idling and verdict
module tb_memory_test_pattern_checker_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mtpc_pkg::*;
  import mtpc_hash_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
  localparam int HOLD_CYCLES = 120;

  logic              clk;
  logic              rst;
  logic              push;
  logic              full;
  logic              op;
  logic [ADDR_W-1:0] word_address;
  logic [PASS_W-1:0] pass_number;
  logic [63:0]       read_data;
  logic              empty;
  logic              pop;
  logic [63:0]       pattern_data;
  logic              mismatch_now;
  logic              fail_seen;
  logic [ADDR_W-1:0] first_fail_address;
  logic [63:0]       first_fail_expected;
  logic [63:0]       first_fail_actual;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_data;

  int fail_count;
  int pending;
  bit idle_on;
  bit hold_req;
  int n_words;
  int n_writes;
  int n_verifies;
  int n_corrupt;
  int n_cfg;

  memory_test_pattern_checker_top u_dut (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .op                 (op),
    .word_address       (word_address),
    .pass_number        (pass_number),
    .read_data          (read_data),
    .empty              (empty),
    .pop                (pop),
    .pattern_data       (pattern_data),
    .mismatch_now       (mismatch_now),
    .fail_seen          (fail_seen),
    .first_fail_address (first_fail_address),
    .first_fail_expected(first_fail_expected),
    .first_fail_actual  (first_fail_actual),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  pattern_result_checker u_chk (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .op                 (op),
    .word_address       (word_address),
    .pass_number        (pass_number),
    .read_data          (read_data),
    .empty              (empty),
    .pop                (pop),
    .pattern_data       (pattern_data),
    .mismatch_now       (mismatch_now),
    .fail_seen          (fail_seen),
    .first_fail_address (first_fail_address),
    .first_fail_expected(first_fail_expected),
    .first_fail_actual  (first_fail_actual),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input op_t kind, input logic [ADDR_W-1:0] addr,
                           input logic [PASS_W-1:0] pass, input logic [63:0] rd);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    op <= kind;
    word_address <= addr;
    pass_number <= pass;
    read_data <= rd;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    n_words++;
    if (kind == OP_WRITE) n_writes++;
    else n_verifies++;
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_inject(input logic value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  function automatic logic [ADDR_W-1:0] rand_addr();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ADDR_MAX;
      2: return ADDR_W'($urandom_range(0, 15));
      default: return ADDR_W'($urandom);
    endcase
  endfunction

  // mostly write/verify pairs on one address, some corrupted read-backs, some noise
  task automatic run_random(input int count);
    int done;
    logic [ADDR_W-1:0] addr;
    logic [PASS_W-1:0] pass;
    logic [63:0] rd;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 9) < 7) begin
        addr = rand_addr();
        pass = PASS_W'($urandom_range(0, 7));
        send_word(OP_WRITE, addr, pass, {$urandom, $urandom});
        rd = hash_pattern(addr, pass);
        if ($urandom_range(0, 99) < 12) begin
          rd = rd ^ (64'd1 << $urandom_range(0, 63));
          n_corrupt++;
        end
        send_word(OP_VERIFY, addr, pass, rd);
        done += 2;
      end else begin
        send_word(op_t'($urandom_range(0, 1)), rand_addr(), PASS_W'($urandom_range(0, 7)),
                  {$urandom, $urandom});
        done++;
      end
    end
  endtask

  // result side
  initial begin
    int gap;
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    #1000000;
    $display("timeout with %0d words still expected", pending);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst = 1'b1;
    push = 1'b0;
    op = OP_WRITE;
    word_address = '0;
    pass_number = '0;
    read_data = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    n_words = 0;
    n_writes = 0;
    n_verifies = 0;
    n_corrupt = 0;
    n_cfg = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // injection off, nothing captured yet
    send_word(OP_WRITE, '0, '0, '1);
    send_word(OP_VERIFY, '0, '0, hash_pattern('0, '0));
    send_word(OP_WRITE, ADDR_MAX, '1, '0);
    send_word(OP_VERIFY, ADDR_MAX, '1, hash_pattern(ADDR_MAX, '1));
    send_word(OP_WRITE, '0, '1, 64'h5555_5555_5555_5555);
    send_word(OP_WRITE, ADDR_MAX, '0, 64'haaaa_aaaa_aaaa_aaaa);
    send_word(OP_VERIFY, 31'h5555_5555, 3'd3, hash_pattern(31'h5555_5555, 3'd3));
    send_word(OP_VERIFY, 31'h2aaa_aaaa, 3'd4, hash_pattern(31'h2aaa_aaaa, 3'd4));
    wait_idle();
    set_inject(1'b1);

    // injection on: only address 0 pass 0 writes flip bit 0
    send_word(OP_WRITE, '0, '0, '0);
    send_word(OP_WRITE, '0, 3'd1, '0);
    send_word(OP_WRITE, 31'd1, '0, '0);
    send_word(OP_VERIFY, '0, '0, hash_pattern('0, '0));
    send_word(OP_VERIFY, '0, '0, hash_pattern('0, '0) ^ 64'd1);
    send_word(OP_VERIFY, ADDR_MAX, '1, '0);
    send_word(OP_VERIFY, 31'd42, 3'd5, '1);
    send_word(OP_VERIFY, 31'd42, 3'd5, hash_pattern(31'd42, 3'd5));
    send_word(OP_WRITE, 31'd42, 3'd5, '1);
    send_word(OP_WRITE, '0, '0, '1);
    wait_idle();
    set_inject(1'b0);

    run_random(500);
    // receiver holds off while the sender keeps pushing, so the input stalls
    idle_on = 1'b0;
    hold_req = 1'b1;
    run_random(60);
    idle_on = 1'b1;
    wait_idle();
    set_inject(1'b1);

    run_random(500);
    idle_on = 1'b0;
    run_random(300);
    idle_on = 1'b1;
    wait_idle();
    set_inject(1'b0);

    run_random(500);
    wait_idle();
    repeat (10) @(negedge clk);

    $display("sent %0d words: %0d writes, %0d verifies, %0d read-backs corrupted on purpose",
             n_words, n_writes, n_verifies, n_corrupt);
    $display("inject_error written %0d times, with random idling and one long result stall",
             n_cfg);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
